[src/ll1r_pkg.sv]
// Shared types and constants for the LL(1) recognizer.
// No dependencies.
package ll1r_pkg;

	typedef enum logic [2:0] {
		ACT_TABLE  = 3'd0,
		ACT_SYMBOL = 3'd1,
		ACT_LENGTH = 3'd2,
		ACT_START  = 3'd3,
		ACT_TOKEN  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ACCEPT   = 2'd1,
		ST_REJECT   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		EX_IDLE,
		EX_TOP,
		EX_TABLE,
		EX_RULE,
		EX_PUSH,
		EX_MATCH,
		EX_DONE
	} exec_state_t;

	localparam int unsigned REG_START_SYMBOL = 0;
	localparam int unsigned REG_END_TERMINAL = 1;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] nonterminal_index;
		logic [3:0] terminal_index;
		logic [4:0] rule_number;
		logic       entry_valid;
		logic [2:0] symbol_position;
		logic [4:0] symbol_code;
		logic [3:0] rule_length;
		logic       token_known;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] stack_depth;
	} out_item_t;

endpackage

[src/ll1r_if.sv]
// Valid/ready channel interfaces for the LL(1) recognizer.
// Depends on ll1r_pkg.
interface ll1r_in_if
	import ll1r_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ll1r_out_if
	import ll1r_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/ll1_table_driven_recognizer_top.sv]
// LL(1) recognizer top level: register port, request queue and parse engine.
// Throughput: one item at a time in the engine; the two-entry queue takes requests meanwhile.
// Each expansion walks through the table, rule and stack memory lookups.
// Reset (arst_n low) empties the parse table and stack and clears both registers.
// Depends on ll1r_pkg, ll1r_if, ll1r_front and ll1r_engine.
module ll1_table_driven_recognizer_top
	import ll1r_pkg::*;
#(
	parameter int NUM_TERMINALS    = 16,
	parameter int NUM_NONTERMINALS = 16,
	parameter int NUM_RULES        = 32,
	parameter int MAX_RULE_LEN     = 8,
	parameter int STACK_DEPTH      = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ll1r_in_if.sink     in_ch,
	ll1r_out_if.source  out_ch
);
	logic [3:0] start_symbol_q, end_terminal_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_symbol_q <= '0;
			end_terminal_q <= '0;
		end else if (wr) begin
			if (paddr == 3'(REG_START_SYMBOL * 4)) start_symbol_q <= pwdata[3:0];
			if (paddr == 3'(REG_END_TERMINAL * 4)) end_terminal_q <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == 3'(REG_START_SYMBOL * 4)) prdata = {28'd0, start_symbol_q};
		else if (paddr == 3'(REG_END_TERMINAL * 4)) prdata = {28'd0, end_terminal_q};
	end

	logic     q_valid, q_pop;
	in_item_t q_item;

	ll1r_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	ll1r_engine #(
		.NUM_TERMINALS(NUM_TERMINALS), .NUM_NONTERMINALS(NUM_NONTERMINALS),
		.NUM_RULES(NUM_RULES), .MAX_RULE_LEN(MAX_RULE_LEN), .STACK_DEPTH(STACK_DEPTH)
	) u_engine (
		.clk(clk), .arst_n(arst_n),
		.start_symbol(start_symbol_q), .end_terminal(end_terminal_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload)
	);
endmodule

[src/ll1r_front.sv]
// Front end: accepts requests into a short queue for the engine.
// Depends on ll1r_pkg.
module ll1r_front
	import ll1r_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     q_valid,
	input  logic     q_pop,
	output in_item_t q_item
);
	in_item_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

[src/ll1r_engine.sv]
// Back end: table loads and the predictive parse sequencer.
// Depends on ll1r_pkg.
module ll1r_engine
	import ll1r_pkg::*;
#(
	parameter int NUM_TERMINALS    = 16,
	parameter int NUM_NONTERMINALS = 16,
	parameter int NUM_RULES        = 32,
	parameter int MAX_RULE_LEN     = 8,
	parameter int STACK_DEPTH      = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [3:0] start_symbol,
	input  logic [3:0] end_terminal,
	input  logic      q_valid,
	output logic      q_pop,
	input  in_item_t  q_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam int TW  = (NUM_NONTERMINALS * NUM_TERMINALS > 1) ?
		$clog2(NUM_NONTERMINALS * NUM_TERMINALS) : 1;
	localparam int RW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam int LW  = $clog2(MAX_RULE_LEN + 1);
	localparam int SW  = $clog2(NUM_RULES * MAX_RULE_LEN);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int TN  = NUM_NONTERMINALS * NUM_TERMINALS;
	localparam int BUDGET    = STACK_DEPTH * (NUM_NONTERMINALS + 1);
	localparam int BW        = $clog2(BUDGET + 1);
	localparam int SYMS      = NUM_RULES * MAX_RULE_LEN;

	// table: rule in memory, valid bit per entry in flops
	logic [4:0]     tab_mem [TN];
	logic [TN-1:0]  tab_vld_q;
	logic [4:0]     sym_mem [SYMS];
	logic [LW-1:0]  len_mem [NUM_RULES];
	logic [4:0]     stk_mem [STACK_DEPTH];

	exec_state_t    state_q, state_d;
	logic [SPW-1:0] sp_q;
	logic [1:0]     pst_q;
	logic [BW-1:0]  budget_q;
	logic [3:0]     tok_q;
	logic [4:0]     top_q;
	logic           tvld_q;
	logic [4:0]     trule_q;
	logic [RW-1:0]  rule_q;
	logic [LW-1:0]  k_q;
	logic [4:0]     sym_rd_q;
	logic           out_valid_q;
	out_item_t      out_q;

	in_item_t it;
	assign it = q_item;

	logic [TW-1:0] tab_idx_w;
	assign tab_idx_w = TW'(32'(it.nonterminal_index) * NUM_TERMINALS +
		32'(it.terminal_index));

	// table entry for the nonterminal on top and the current token
	logic [TW-1:0] taddr_w;
	assign taddr_w = TW'(32'(top_q[3:0]) * NUM_TERMINALS + 32'(tok_q));

	// sequencer control
	logic do_start, do_load, finish;
	logic [1:0] fin_status;

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		finish     = 1'b0;
		fin_status = ST_OK;
		do_start   = 1'b0;
		do_load    = 1'b0;
		unique case (state_q)
			EX_IDLE: begin
				if (q_valid && !out_valid_q) begin
					if (it.action == ACT_TOKEN) begin
						if (pst_q != ST_OK) begin
							q_pop = 1'b1; finish = 1'b1; fin_status = pst_q;
						end else if (!it.token_known ||
								32'(it.terminal_index) >= NUM_TERMINALS) begin
							q_pop = 1'b1; finish = 1'b1; fin_status = ST_REJECT;
						end else begin
							q_pop = 1'b1; state_d = EX_TOP;
						end
					end else begin
						q_pop = 1'b1; finish = 1'b1; fin_status = ST_OK;
						if (it.action == ACT_START) do_start = 1'b1;
						else do_load = 1'b1;
					end
				end
			end
			EX_TOP: begin
				if (sp_q == '0) begin
					finish = 1'b1; fin_status = ST_REJECT; state_d = EX_IDLE;
				end else state_d = EX_TABLE;
			end
			EX_TABLE: begin
				// top_q valid here
				if (!top_q[4]) state_d = EX_MATCH;
				else if (32'(top_q[3:0]) >= NUM_NONTERMINALS || budget_q == '0) begin
					finish = 1'b1; fin_status = ST_REJECT; state_d = EX_IDLE;
				end else state_d = EX_RULE;
			end
			EX_RULE: begin
				if (!tvld_q || 32'(trule_q) >= NUM_RULES) begin
					finish = 1'b1; fin_status = ST_REJECT; state_d = EX_IDLE;
				end else state_d = EX_PUSH;
			end
			EX_PUSH: begin
				// k_q loaded from length; one symbol fetched per pass through EX_PUSH and EX_DONE
				if (k_q == '0) state_d = EX_TOP;
				else if (32'(sp_q) >= STACK_DEPTH) begin
					finish = 1'b1; fin_status = ST_OVERFLOW; state_d = EX_IDLE;
				end else state_d = EX_DONE;
			end
			EX_DONE: state_d = EX_PUSH; // symbol read settles
			EX_MATCH: begin
				finish = 1'b1; state_d = EX_IDLE;
				if (top_q[3:0] != tok_q) fin_status = ST_REJECT;
				else if (tok_q == end_terminal) fin_status = ST_ACCEPT;
				else fin_status = ST_OK;
			end
			default: state_d = EX_IDLE;
		endcase
	end

	logic [LW-1:0] len_sat;
	assign len_sat = (32'(it.rule_length) > MAX_RULE_LEN) ? LW'(MAX_RULE_LEN) :
		LW'(it.rule_length);

	logic [SW-1:0] sym_wa;
	assign sym_wa = SW'(32'(it.rule_number) * MAX_RULE_LEN + 32'(it.symbol_position));
	logic [SW-1:0] sym_ra;
	assign sym_ra = SW'(32'(rule_q) * MAX_RULE_LEN + 32'(k_q) - 1);

	// memories
	always_ff @(posedge clk) begin
		if (do_load && it.action == ACT_TABLE &&
				32'(it.nonterminal_index) < NUM_NONTERMINALS &&
				32'(it.terminal_index) < NUM_TERMINALS && it.entry_valid &&
				32'(it.rule_number) < NUM_RULES)
			tab_mem[tab_idx_w] <= it.rule_number;
		if (do_load && it.action == ACT_SYMBOL && 32'(it.rule_number) < NUM_RULES &&
				32'(it.symbol_position) < MAX_RULE_LEN)
			sym_mem[sym_wa] <= it.symbol_code;
		if (do_load && it.action == ACT_LENGTH && 32'(it.rule_number) < NUM_RULES)
			len_mem[RW'(it.rule_number)] <= len_sat;
		// reads
		trule_q  <= tab_mem[taddr_w];
		sym_rd_q <= sym_mem[sym_ra];
		top_q    <= stk_mem[SAW'(sp_q - 1'b1)];
		if (do_start) begin
			stk_mem[0] <= {1'b0, end_terminal};
			stk_mem[1] <= {1'b1, start_symbol};
		end else if (state_q == EX_DONE)
			stk_mem[SAW'(sp_q)] <= sym_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EX_IDLE;
			tab_vld_q   <= '0;
			sp_q        <= '0;
			pst_q       <= ST_OK;
			budget_q    <= '0;
			tok_q       <= '0;
			tvld_q      <= 1'b0;
			rule_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q <= state_d;
			if (do_load && it.action == ACT_TABLE &&
					32'(it.nonterminal_index) < NUM_NONTERMINALS &&
					32'(it.terminal_index) < NUM_TERMINALS &&
					(!it.entry_valid || 32'(it.rule_number) < NUM_RULES))
				tab_vld_q[tab_idx_w] <= it.entry_valid;
			if (do_start) begin
				sp_q  <= SPW'(2);
				pst_q <= ST_OK;
			end
			if (state_q == EX_IDLE && state_d == EX_TOP) begin
				tok_q    <= it.terminal_index;
				budget_q <= BW'(BUDGET);
			end
			if (state_q == EX_TABLE && state_d == EX_RULE) begin
				budget_q <= budget_q - 1'b1;
				tvld_q   <= tab_vld_q[taddr_w];
			end
			// trule_q was read from the table during EX_TABLE
			if (state_q == EX_RULE && state_d == EX_PUSH) begin
				rule_q <= RW'(trule_q);
				sp_q   <= sp_q - 1'b1;
				k_q    <= len_mem[RW'(trule_q)];
			end
			if (state_q == EX_DONE) begin
				sp_q <= sp_q + 1'b1;
				k_q  <= k_q - 1'b1;
			end
			if (state_q == EX_MATCH && top_q[3:0] == tok_q) sp_q <= sp_q - 1'b1;
			if (finish && (state_q != EX_IDLE || it.action == ACT_TOKEN)) begin
				pst_q <= fin_status;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				out_q.status <= fin_status;
				out_q.stack_depth <=
					(state_q == EX_MATCH && top_q[3:0] == tok_q) ? 7'(sp_q - 1'b1) :
					do_start ? 7'd2 : 7'(sp_q);
			end else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

[tb/sv/ll1_table_driven_recognizer_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LL(1) recognizer top level.
// Predicts each result as requests are generated and checks them in order on the output.
// Depends on ll1r_pkg, ll1r_if and ll1_table_driven_recognizer_top.
module ll1_table_driven_recognizer_top_tb;
	import ll1r_pkg::*;

	localparam int N_TERM      = 16;
	localparam int N_NONTERM   = 16;
	localparam int N_RULES     = 32;
	localparam int RULE_MAX    = 8;
	localparam int STK_MAX     = 64;
	localparam int EXPAND_CAP  = STK_MAX * (N_NONTERM + 1);
	localparam int CYCLE_LIMIT = 40000000;
	localparam int RANDOM_ITEMS = 510;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ll1r_in_if  in_ch ();
	ll1r_out_if out_ch ();

	ll1_table_driven_recognizer_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the parser state
	logic [5:0] pred_table [N_NONTERM*N_TERM];
	logic [4:0] rule_syms [N_RULES*RULE_MAX];
	logic [3:0] rule_lens [N_RULES];
	logic [4:0] sym_stack [STK_MAX];
	int         stk_ptr;
	status_t    parse_st;
	logic [3:0] cfg_start;
	logic [3:0] cfg_end;

	in_item_t   pending_reqs [$];
	out_item_t  expected_results [$];
	int         accepted_cnt, received_cnt, err_cnt, cycle_cnt;
	int         in_wait, out_wait, hold_cnt;
	int         accept_seen, reject_seen, overflow_seen, token_cnt;
	bit         idle_on = 1'b1;
	bit         hold_req = 1'b0;

	function automatic void run_token(logic [3:0] tok, logic known);
		int         budget;
		logic [4:0] top;
		logic [5:0] ent;
		int         r, len, k;
		budget = EXPAND_CAP;
		if (parse_st != ST_OK) return;
		if (!known) begin
			parse_st = ST_REJECT;
			return;
		end
		forever begin
			if (stk_ptr == 0) begin
				parse_st = ST_REJECT;
				return;
			end
			top = sym_stack[stk_ptr-1];
			if (!top[4]) break;
			if (budget == 0) begin
				parse_st = ST_REJECT;
				return;
			end
			budget--;
			ent = pred_table[{top[3:0], tok}];
			if (!ent[5]) begin
				parse_st = ST_REJECT;
				return;
			end
			r = ent[4:0];
			len = rule_lens[r];
			stk_ptr--;
			for (k = len; k > 0; k--) begin
				if (stk_ptr >= STK_MAX) begin
					parse_st = ST_OVERFLOW;
					return;
				end
				sym_stack[stk_ptr] = rule_syms[r*RULE_MAX + k - 1];
				stk_ptr++;
			end
		end
		if (top[3:0] != tok) begin
			parse_st = ST_REJECT;
			return;
		end
		stk_ptr--;
		if (tok == cfg_end) parse_st = ST_ACCEPT;
	endfunction

	function automatic out_item_t parse_outcome(in_item_t it);
		out_item_t o;
		status_t   st;
		st = ST_OK;
		case (it.action)
			ACT_TABLE: begin
				if (!it.entry_valid)
					pred_table[{it.nonterminal_index, it.terminal_index}] = '0;
				else
					pred_table[{it.nonterminal_index, it.terminal_index}] = {1'b1, it.rule_number};
			end
			ACT_SYMBOL: rule_syms[it.rule_number*RULE_MAX + it.symbol_position] = it.symbol_code;
			ACT_LENGTH: rule_lens[it.rule_number] = (it.rule_length > RULE_MAX) ? 4'(RULE_MAX)
				: it.rule_length;
			ACT_START: begin
				sym_stack[0] = {1'b0, cfg_end};
				sym_stack[1] = {1'b1, cfg_start};
				stk_ptr = 2;
				parse_st = ST_OK;
			end
			ACT_TOKEN: begin
				run_token(it.terminal_index, it.token_known);
				st = parse_st;
				token_cnt++;
				if (st == ST_ACCEPT) accept_seen++;
				if (st == ST_REJECT) reject_seen++;
				if (st == ST_OVERFLOW) overflow_seen++;
			end
			default: ;
		endcase
		o.status = st;
		o.stack_depth = stk_ptr[6:0];
		return o;
	endfunction

	function automatic in_item_t noise_item();
		logic [29:0] v;
		v = 30'($urandom);
		return in_item_t'(v);
	endfunction

	task automatic queue_req(in_item_t it);
		expected_results.insert(expected_results.size(), parse_outcome(it));
		pending_reqs.insert(pending_reqs.size(), it);
	endtask

	task automatic queue_table(int nt, int t, int r, bit ok);
		in_item_t it;
		it = noise_item();
		it.action = ACT_TABLE;
		it.nonterminal_index = 4'(nt);
		it.terminal_index = 4'(t);
		it.rule_number = 5'(r);
		it.entry_valid = ok;
		queue_req(it);
	endtask

	task automatic queue_symbol(int r, int p, logic [4:0] code);
		in_item_t it;
		it = noise_item();
		it.action = ACT_SYMBOL;
		it.rule_number = 5'(r);
		it.symbol_position = 3'(p);
		it.symbol_code = code;
		queue_req(it);
	endtask

	task automatic queue_length(int r, int len);
		in_item_t it;
		it = noise_item();
		it.action = ACT_LENGTH;
		it.rule_number = 5'(r);
		it.rule_length = 4'(len);
		queue_req(it);
	endtask

	task automatic queue_start();
		in_item_t it;
		it = noise_item();
		it.action = ACT_START;
		queue_req(it);
	endtask

	task automatic queue_token(int t, bit known);
		in_item_t it;
		it = noise_item();
		it.action = ACT_TOKEN;
		it.terminal_index = 4'(t);
		it.token_known = known;
		queue_req(it);
	endtask

	// Pick a token that the current stack top can take, most of the time
	function automatic int steer_token();
		logic [4:0] top;
		int         opts [$];
		if (stk_ptr == 0 || parse_st != ST_OK || $urandom_range(0, 9) == 0)
			return $urandom_range(0, N_TERM-1);
		top = sym_stack[stk_ptr-1];
		if (!top[4]) return top[3:0];
		for (int t = 0; t < N_TERM; t++)
			if (pred_table[{top[3:0], 4'(t)}][5]) opts.insert(opts.size(), t);
		if (opts.size() == 0) return $urandom_range(0, N_TERM-1);
		return opts[$urandom_range(0, opts.size()-1)];
	endfunction

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(int idx, logic [3:0] v);
		drain();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx*4);
		pwdata <= {28'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_START_SYMBOL) cfg_start = v;
		else cfg_end = v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[3:0] !== v)
			$error("register %0d: expected %0h, actual %0h", idx, v, prdata[3:0]);
		if (prdata[3:0] !== v) err_cnt++;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// New random grammar over nonterminals below nnt
	task automatic load_grammar(int nnt);
		int r, len;
		logic [4:0] code;
		repeat (8) begin
			r = $urandom_range(0, N_RULES-1);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
			for (int p = 0; p < RULE_MAX && p <= len; p++) begin
				if ($urandom_range(0, 2) == 0) code = {1'b1, 4'($urandom_range(0, nnt-1))};
				else code = {1'b0, 4'($urandom)};
				queue_symbol(r, p, code);
			end
			queue_length(r, len);
		end
		for (int n = 0; n < nnt; n++)
			for (int t = 0; t < N_TERM; t++) begin
				if ($urandom_range(0, 3) == 0)
					queue_table(n, t, $urandom_range(0, N_RULES-1), 1'b1);
				else if (pred_table[{4'(n), 4'(t)}][5] && $urandom_range(0, 2) == 0)
					queue_table(n, t, $urandom_range(0, N_RULES-1), 1'b0);
			end
	endtask

	// Request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				accepted_cnt++;
				in_wait = idle_on ? $urandom_range(0, 5) : 0;
			end
			if (in_ch.valid && !in_ch.ready) begin
			end else if (in_wait > 0) begin
				in_wait--;
				in_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.payload <= pending_reqs.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (received_cnt >= accepted_cnt || expected_results.size() == 0) begin
					$error("result with no request outstanding: %p", out_ch.payload);
					err_cnt++;
				end else begin
					e = expected_results.pop_front();
					if (out_ch.payload.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status,
							out_ch.payload.status);
						err_cnt++;
					end
					if (out_ch.payload.stack_depth !== e.stack_depth) begin
						$error("stack_depth: expected %0d, actual %0d", e.stack_depth,
							out_ch.payload.stack_depth);
						err_cnt++;
					end
				end
				received_cnt++;
				out_wait = idle_on ? $urandom_range(0, 5) : 0;
			end
			if (hold_req && hold_cnt == 0) begin
				hold_cnt = 400;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("ll1_table_driven_recognizer_top_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int gen, phase_end, nnt, steps;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		foreach (pred_table[i]) pred_table[i] = '0;
		foreach (rule_syms[i]) rule_syms[i] = '0;
		foreach (rule_lens[i]) rule_lens[i] = '0;
		foreach (sym_stack[i]) sym_stack[i] = '0;
		stk_ptr = 0;
		parse_st = ST_OK;
		cfg_start = '0;
		cfg_end = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Token ahead of any start, then the unused action codes
		queue_token(1, 1'b1);
		for (int a = 5; a < 8; a++) begin
			in_item_t it;
			it = noise_item();
			it.action = 3'(a);
			queue_req(it);
		end
		// Give every rule defined content before any expansion can read it
		for (int r = 0; r < N_RULES; r++) begin
			for (int p = 0; p < RULE_MAX; p++) queue_symbol(r, p, 5'($urandom));
			queue_length(r, $urandom_range(0, 8));
		end
		queue_length(31, 15);

		cfg_write(REG_START_SYMBOL, 4'd0);
		cfg_write(REG_END_TERMINAL, 4'd15);
		// S -> a N1 ; N1 -> epsilon ; N2 -> N2 ; N3 -> N3 x7
		queue_symbol(0, 0, 5'd1);
		queue_symbol(0, 1, 5'h11);
		queue_length(0, 2);
		queue_length(1, 0);
		queue_symbol(2, 0, 5'h12);
		queue_length(2, 1);
		queue_symbol(3, 0, 5'h13);
		for (int p = 1; p < RULE_MAX; p++) queue_symbol(3, p, 5'd9);
		queue_length(3, 8);
		queue_table(0, 1, 0, 1'b1);
		queue_table(0, 5, 0, 1'b1);
		queue_table(1, 15, 1, 1'b1);
		queue_table(2, 2, 2, 1'b1);
		queue_table(3, 3, 3, 1'b1);
		queue_start();
		queue_token(1, 1'b1);
		queue_token(15, 1'b1);
		queue_token(4, 1'b1);
		queue_start();
		queue_token(1, 1'b0);
		queue_start();
		queue_token(7, 1'b1);
		queue_start();
		queue_token(5, 1'b1);
		queue_table(0, 5, 0, 1'b0);
		queue_start();
		queue_token(5, 1'b1);
		queue_start();
		queue_token(1, 1'b1);
		queue_token(4, 1'b1);
		cfg_write(REG_START_SYMBOL, 4'd2);
		queue_start();
		queue_token(2, 1'b1);
		cfg_write(REG_START_SYMBOL, 4'd3);
		queue_start();
		queue_token(3, 1'b1);
		queue_token(3, 1'b1);
		// Move the end marker after a start so the stack can run dry
		cfg_write(REG_START_SYMBOL, 4'd0);
		queue_start();
		cfg_write(REG_END_TERMINAL, 4'd0);
		queue_token(1, 1'b1);
		queue_token(15, 1'b1);
		queue_token(6, 1'b1);

		gen = 0;
		for (int g = 0; gen < RANDOM_ITEMS; g++) begin
			nnt = (g % 4 == 3) ? N_NONTERM : $urandom_range(2, 6);
			drain();
			idle_on = (g % 3 != 2);
			cfg_write(REG_START_SYMBOL, (g == 0) ? 4'd0 : (g == 1) ? 4'(nnt-1)
				: 4'($urandom_range(0, nnt-1)));
			cfg_write(REG_END_TERMINAL, (g == 0) ? 4'd0 : (g == 1) ? 4'd15 : 4'($urandom));
			steps = pending_reqs.size();
			load_grammar(nnt);
			gen += pending_reqs.size() - steps;
			if (g == 2) hold_req = 1'b1;
			phase_end = gen + 130;
			while (gen < phase_end && gen < RANDOM_ITEMS) begin
				if (g == 4 && gen > phase_end - 60 && gen < phase_end - 50) drain();
				if ($urandom_range(0, 9) == 0) begin
					queue_req(noise_item());
					gen++;
				end else begin
					queue_start();
					gen++;
					steps = $urandom_range(1, 40);
					while (steps > 0 && parse_st == ST_OK) begin
						queue_token(steer_token(), $urandom_range(0, 29) != 0);
						gen++;
						steps--;
					end
					if ($urandom_range(0, 3) == 0) begin
						queue_token($urandom_range(0, N_TERM-1), 1'b1);
						gen++;
					end
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d requests, %0d tokens: %0d accepted, %0d rejected, %0d overflowed.",
			accepted_cnt, token_cnt, accept_seen, reject_seen, overflow_seen);
		if (err_cnt == 0 && expected_results.size() == 0 && received_cnt == accepted_cnt)
			$display("ll1_table_driven_recognizer_top_tb OK");
		else
			$display("ll1_table_driven_recognizer_top_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
src/ll1r_pkg.sv
src/ll1r_if.sv
src/ll1r_front.sv
src/ll1r_engine.sv
src/ll1_table_driven_recognizer_top.sv
tb/sv/ll1_table_driven_recognizer_top_tb.sv
